// ===== src/wsw_pkg.sv =====
// ----------------------------------------------------------------------------
// wsw_pkg: shared types and constants
// Sizing constants, queue entry type and hash round functions for the
// jitter seed whitener.
// ----------------------------------------------------------------------------
package wsw_pkg;

    localparam int SAMPLES_PER_SEED = 32;
    localparam int SEED_SLOTS       = 8;

    localparam int CNT_W  = (SAMPLES_PER_SEED > 1) ? $clog2(SAMPLES_PER_SEED) : 1;
    localparam int SLOT_W = (SEED_SLOTS > 1) ? $clog2(SEED_SLOTS) : 1;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // one classified sample on its way to the hash datapath
    typedef struct packed {
        logic [7:0]        sample;
        logic [SLOT_W-1:0] slot;
        logic              fin;    // this sample completes the slot
        logic              last;   // completed slot is the final one
    } t_entry;

    // one-at-a-time round on one byte
    function automatic logic [31:0] fold_byte(input logic [31:0] h, input logic [7:0] b);
        logic [31:0] s;
        s = h + {24'd0, b};
        s = s + (s << 10);
        return s ^ (s >> 6);
    endfunction

    // first half of the final mix
    function automatic logic [31:0] mix_a(input logic [31:0] h);
        logic [31:0] s;
        s = h + (h << 3);
        return s ^ (s >> 11);
    endfunction

    // second half of the final mix
    function automatic logic [31:0] mix_b(input logic [31:0] h);
        return h + (h << 15);
    endfunction

endpackage

// ===== src/wsw_front.sv =====
// ----------------------------------------------------------------------------
// wsw_front: sample intake
// Accepts sample requests, tracks sample count and slot index, and tags
// each sample with its slot and end-of-slot flags.
// ----------------------------------------------------------------------------
module wsw_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_sample_valid,
    output logic            o_sample_ready,
    input  logic [7:0]      i_sample_byte,
    input  logic            i_q_full,
    output logic            o_push,
    output wsw_pkg::t_entry o_entry
);
    import wsw_pkg::*;

    logic [CNT_W-1:0]  r_cnt,  n_cnt;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic              fin, last;

    assign o_sample_ready = !i_q_full;
    assign o_push         = i_sample_valid && !i_q_full;

    assign fin  = (r_cnt == CNT_W'(SAMPLES_PER_SEED - 1));
    assign last = fin && (r_slot == SLOT_W'(SEED_SLOTS - 1));

    always_comb begin
        o_entry.sample = i_sample_byte;
        o_entry.slot   = r_slot;
        o_entry.fin    = fin;
        o_entry.last   = last;
    end

    always_comb begin
        n_cnt  = r_cnt;
        n_slot = r_slot;
        if (o_push) begin
            n_cnt = fin ? '0 : r_cnt + 1'b1;
            if (fin) begin
                n_slot = last ? '0 : r_slot + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_slot <= '0;
        end else begin
            r_cnt  <= n_cnt;
            r_slot <= n_slot;
        end
    end

endmodule

// ===== src/wsw_fifo.sv =====
// ----------------------------------------------------------------------------
// wsw_fifo: sample queue
// Short first-in first-out queue between intake and hash datapath.
// ----------------------------------------------------------------------------
module wsw_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  wsw_pkg::t_entry i_entry,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output wsw_pkg::t_entry o_entry
);
    import wsw_pkg::*;

    t_entry          r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr, r_rd;
    logic [Q_AW:0]   r_count;

    assign o_full  = (r_count == (Q_AW+1)'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== src/wsw_back.sv =====
// ----------------------------------------------------------------------------
// wsw_back: hash datapath
// Folds queued samples into the slot store, runs the two-stage final mix
// and holds finished seeds in the output register.
// ----------------------------------------------------------------------------
module wsw_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  wsw_pkg::t_entry i_entry,
    output logic            o_pop,
    output logic            o_seed_valid,
    input  logic            i_seed_ready,
    output logic [31:0]     o_seed_word,
    output logic [2:0]      o_seed_slot,
    output logic            o_round_last
);
    import wsw_pkg::*;

    logic [31:0]       r_store [SEED_SLOTS];

    logic              r_m_vld, r_f_vld, r_o_vld;
    logic [31:0]       r_m_h, r_f_h, r_o_word;
    logic [SLOT_W-1:0] r_m_slot, r_f_slot, r_o_slot;
    logic              r_m_last, r_f_last, r_o_last;

    logic [31:0] fold_h, mixa_h, mixb_h;
    logic        f_adv, m_adv, m_free, hazard, pop_fin;

    // pipeline advance, from the output back
    assign f_adv  = r_f_vld && (!r_o_vld || i_seed_ready);
    assign m_adv  = r_m_vld && (!r_f_vld || f_adv);
    assign m_free = !r_m_vld || m_adv;

    // a slot in the middle of its final mix is not touched again until written
    assign hazard = (r_m_vld && (r_m_slot == i_entry.slot))
                 || (r_f_vld && (r_f_slot == i_entry.slot));

    assign o_pop   = i_q_valid && !hazard && (!i_entry.fin || m_free);
    assign pop_fin = o_pop && i_entry.fin;

    assign fold_h = fold_byte(r_store[i_entry.slot], i_entry.sample);
    assign mixa_h = mix_a(r_m_h);
    assign mixb_h = mix_b(r_f_h);

    // slot store: fold write-back, or finished seed from the last mix stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SEED_SLOTS; i++) begin
                r_store[i] <= '0;
            end
        end else begin
            for (int i = 0; i < SEED_SLOTS; i++) begin
                if (o_pop && !i_entry.fin && (i_entry.slot == SLOT_W'(i))) begin
                    r_store[i] <= fold_h;
                end else if (f_adv && (r_f_slot == SLOT_W'(i))) begin
                    r_store[i] <= mixb_h;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop_fin) begin
            r_m_h    <= fold_h;
            r_m_slot <= i_entry.slot;
            r_m_last <= i_entry.last;
        end
        if (m_adv) begin
            r_f_h    <= mixa_h;
            r_f_slot <= r_m_slot;
            r_f_last <= r_m_last;
        end
        if (f_adv) begin
            r_o_word <= mixb_h;
            r_o_slot <= r_f_slot;
            r_o_last <= r_f_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
            r_f_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            r_m_vld <= pop_fin ? 1'b1 : (m_adv ? 1'b0 : r_m_vld);
            r_f_vld <= m_adv ? 1'b1 : (f_adv ? 1'b0 : r_f_vld);
            r_o_vld <= f_adv ? 1'b1 : (i_seed_ready ? 1'b0 : r_o_vld);
        end
    end

    assign o_seed_valid = r_o_vld;
    assign o_seed_word  = r_o_word;
    assign o_seed_slot  = 3'(r_o_slot);
    assign o_round_last = r_o_last;

endmodule

// ===== src/jitter_seed_one_at_a_time_whitener_unit.sv =====
// ----------------------------------------------------------------------------
// jitter_seed_one_at_a_time_whitener_unit: jitter seed whitener top level
// Folds raw jitter sample bytes into seed slots with the one-at-a-time hash
// and emits each slot after its final mix.
// ----------------------------------------------------------------------------
// Throughput: one sample byte per cycle while seeds are taken when offered.
// The seed of a slot, once the request carrying its final sample is accepted,
//   is registered through the queue, the fold register, mix stage A and mix stage B/output.
// A held seed backs up the mix stages, then the queue, then sample intake.
// Reset (synchronous, active low) zeroes the slot store, counters and queue.
// ----------------------------------------------------------------------------
module jitter_seed_one_at_a_time_whitener_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // sample channel
    input  logic        i_sample_valid,
    output logic        o_sample_ready,
    input  logic [7:0]  i_sample_byte,
    // seed channel
    output logic        o_seed_valid,
    input  logic        i_seed_ready,
    output logic [31:0] o_seed_word,
    output logic [2:0]  o_seed_slot,
    output logic        o_round_last
);
    import wsw_pkg::*;

    // front to queue
    logic   push, q_full;
    t_entry push_entry;
    // queue to back
    logic   pop, q_valid;
    t_entry head_entry;

    // Front end: counts samples per slot and tags each request with the slot
    // it belongs to and whether it ends the slot (and the round of slots).
    wsw_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_sample_valid (i_sample_valid),
        .o_sample_ready (o_sample_ready),
        .i_sample_byte  (i_sample_byte),
        .i_q_full       (q_full),
        .o_push         (push),
        .o_entry        (push_entry)
    );

    // Decoupling queue: lets the front keep taking samples while the back
    // end waits on a slot hazard or on the seed consumer.
    wsw_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_entry (head_entry)
    );

    // Back end: one fold per cycle into the slot store unless held by a slot hazard
    // or a busy mix stage; completed slots go through a two-stage final mix, are written back and presented.
    wsw_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_entry      (head_entry),
        .o_pop        (pop),
        .o_seed_valid (o_seed_valid),
        .i_seed_ready (i_seed_ready),
        .o_seed_word  (o_seed_word),
        .o_seed_slot  (o_seed_slot),
        .o_round_last (o_round_last)
    );

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the jitter seed whitener
// Streams sample bytes into the unit, keeps its own model of the
// one-at-a-time seed slots and checks every emitted seed, slot index and last
// flag in order, under several idle and backpressure mixes.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import wsw_pkg::*;

    localparam int REPORT_MAX   = 10;    // mismatches printed in full
    localparam int STALL_LIMIT  = 2000;  // cycles with no request moving
    localparam int DRAIN_CYCLES = 12;    // tail after the last seed
    localparam int RAND_SAMPLES = 1300;
    localparam int PHASE_LEN    = 100;   // samples per idle/stall phase

    // idle mixes, cycled through during the random part
    typedef enum int {
        PH_FLOW,
        PH_TX_IDLE,
        PH_RX_STALL,
        PH_BOTH
    } t_phase;

    // -------------------------------------------------------------------------
    // Seed scoreboard: predicts seeds from accepted samples, checks outputs.
    // -------------------------------------------------------------------------
    class seed_scoreboard;
        typedef struct packed {
            logic [31:0] word;
            logic [2:0]  slot;
            logic        last;
        } t_seed;

        logic [31:0] slot_hash [SEED_SLOTS];
        int unsigned samples_in_slot;
        int unsigned cur_slot;
        t_seed       expected_seeds [$];
        int unsigned mismatches;
        int unsigned seeds_seen;

        function new();
            foreach (slot_hash[k]) slot_hash[k] = '0;
            samples_in_slot = 0;
            cur_slot        = 0;
            mismatches      = 0;
            seeds_seen      = 0;
        endfunction

        // fold one accepted sample; queue a seed when the slot completes
        function void note_sample(logic [7:0] sample);
            logic [31:0] h;
            t_seed       s;
            h = slot_hash[cur_slot] + {24'd0, sample};
            h = h + (h << 10);
            h = h ^ (h >> 6);
            samples_in_slot++;
            if (samples_in_slot < SAMPLES_PER_SEED) begin
                slot_hash[cur_slot] = h;
                return;
            end
            samples_in_slot = 0;
            h = h + (h << 3);
            h = h ^ (h >> 11);
            h = h + (h << 15);
            slot_hash[cur_slot] = h;
            s.word = h;
            s.slot = cur_slot[2:0];
            s.last = (cur_slot + 1 == SEED_SLOTS);
            expected_seeds.push_back(s);
            cur_slot = s.last ? 0 : cur_slot + 1;
        endfunction

        // compare one accepted seed with the oldest prediction
        function void check_seed(logic [31:0] word, logic [2:0] slot, logic last);
            t_seed want;
            seeds_seen++;
            if (expected_seeds.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("seed %0d unexpected: word=%h slot=%0d last=%0b",
                             seeds_seen, word, slot, last);
                return;
            end
            want = expected_seeds.pop_front();
            if (want.word !== word || want.slot !== slot || want.last !== last) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("seed %0d: expected %h/%0d/%0b, got %h/%0d/%0b",
                             seeds_seen, want.word, want.slot, want.last,
                             word, slot, last);
            end
        endfunction
    endclass

    // -------------------------------------------------------------------------
    // DUT signals; the bench-driven inputs are known from time zero
    // -------------------------------------------------------------------------
    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_sample_valid = 1'b0;
    logic        o_sample_ready;
    logic [7:0]  i_sample_byte  = 8'd0;
    logic        o_seed_valid;
    logic        i_seed_ready   = 1'b0;
    logic [31:0] o_seed_word;
    logic [2:0]  o_seed_slot;
    logic        o_round_last;

    seed_scoreboard sb;
    int unsigned    tx_idle_pct = 0;   // chance per cycle the sender holds off
    int unsigned    rx_stall_pct = 0;  // chance per cycle the receiver stalls

    // edge cases up front: all-zero, all-one, single bits, alternating patterns
    localparam logic [7:0] DIRECTED [25] = '{
        8'h00, 8'hFF, 8'h01, 8'h80, 8'h55, 8'hAA, 8'h7F, 8'hFE, 8'h0F, 8'hF0,
        8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'hFD, 8'hFB, 8'hF7, 8'hEF,
        8'hDF, 8'hBF, 8'h33, 8'hCC, 8'hFF
    };

    jitter_seed_one_at_a_time_whitener_unit i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_sample_valid (i_sample_valid),
        .o_sample_ready (o_sample_ready),
        .i_sample_byte  (i_sample_byte),
        .o_seed_valid   (o_seed_valid),
        .i_seed_ready   (i_seed_ready),
        .o_seed_word    (o_seed_word),
        .o_seed_slot    (o_seed_slot),
        .o_round_last   (o_round_last)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // -------------------------------------------------------------------------
    // Sample request driver. Valid is only lowered on an idle cycle, so a
    // back-to-back request never sees valid dropped and raised in one step.
    // Handshake is judged on the values that held at the edge.
    // -------------------------------------------------------------------------
    task automatic send_sample(input logic [7:0] sample);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_sample_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_sample_valid <= 1'b1;
        i_sample_byte  <= sample;
        do @(posedge i_clk); while (!o_sample_ready);
        sb.note_sample(sample);
    endtask

    task automatic set_phase(input t_phase ph);
        case (ph)
            PH_FLOW: begin
                tx_idle_pct  = 0;
                rx_stall_pct = 0;
            end
            PH_TX_IDLE: begin
                tx_idle_pct  = 82;
                rx_stall_pct = 0;
            end
            PH_RX_STALL: begin
                tx_idle_pct  = 0;
                rx_stall_pct = 82;
            end
            default: begin
                tx_idle_pct  = 22;
                rx_stall_pct = 22;
            end
        endcase
    endtask

    // -------------------------------------------------------------------------
    // Seed receiver: check on an accepted request, then pick next ready.
    // Only one nonblocking write to ready per edge.
    // -------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_seed_valid && i_seed_ready)
            sb.check_seed(o_seed_word, o_seed_slot, o_round_last);
        i_seed_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end

    // -------------------------------------------------------------------------
    // Watchdog: ends the run if no request moves on either side for too long.
    // -------------------------------------------------------------------------
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_sample_valid && o_sample_ready) || (o_seed_valid && i_seed_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // -------------------------------------------------------------------------
    // Main sequence: reset, directed samples, random phases, drain, verdict.
    // -------------------------------------------------------------------------
    initial begin
        int unsigned n;
        logic [7:0]  sample;
        sb = new();

        // synchronous reset held, then released once
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_phase(PH_FLOW);
        foreach (DIRECTED[k])
            send_sample(DIRECTED[k]);

        // random part: phases rotate every PHASE_LEN samples so gaps land on
        // every position within a 32-sample slot
        n = 0;
        while (n < RAND_SAMPLES) begin
            set_phase(t_phase'((n / PHASE_LEN) % 4));
            case ($urandom_range(0, 9))
                0:       sample = 8'h00;
                1:       sample = 8'hFF;
                default: sample = 8'($urandom_range(0, 255));
            endcase
            send_sample(sample);
            n++;
        end
        i_sample_valid <= 1'b0;

        // drain with the receiver always ready; watchdog bounds the wait
        set_phase(PH_FLOW);
        while (sb.expected_seeds.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.mismatches == 0 && sb.expected_seeds.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
